@@ hdl/alm_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm monitor package
// Shared status codes, register indexes and widths of the alarm monitor.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned HYST_W          = 31;
  localparam int unsigned SEVS_W          = 8;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned SEV_W           = 2;
  localparam int unsigned RES_W           = STATUS_W + SEV_W + 4;
  localparam int unsigned RES_TDATA_W     = ((RES_W + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] ST_NONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIHI = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOLO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIGH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOW  = 3'd4;

  localparam logic [SEV_W-1:0] SEV_NONE = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIHI = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOLO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MON_DB     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_DB    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEVS       = 3'd7;

  typedef struct packed {
    logic                archive_event;
    logic                value_event;
    logic                status_changed;
    logic                severity_changed;
    logic [SEV_W-1:0]    alarm_severity;
    logic [STATUS_W-1:0] alarm_status;
  } result_t;

endpackage

@@ hdl/alarm_limit_and_deadband_monitor.sv @@
// ----------------------------------------------------------------------------
// Alarm limit and deadband monitor
// Four-level alarm check with hysteresis plus value and archive deadbands.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one signed fixed-point value per
//   request in s_axis_tdata. Each sample yields exactly one result request on
//   m_axis: alarm status, severity, change flags and deadband event flags.
//   Limits, hysteresis, deadbands and severities are written through the cfg
//   port (write enable, index, data) while no sample is in flight.
//   The pipeline is an input register, then the compare and subtract logic
//   into the result register. Throughput is one sample per cycle while the
//   receiver takes results; the last status, severity and sample are updated
//   as each result is registered, so the next sample sees them at once.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more sample; after that s_axis_tready drops.
//   Reset clears the valid flags of both pipeline stages, all configuration
//   registers and the last status, severity and sample to zero.
// ----------------------------------------------------------------------------
module alarm_limit_and_deadband_monitor #(
  parameter int unsigned VALUE_WIDTH = alm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [alm_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [alm_pkg::CFG_DATA_W-1:0]              cfg_data_i,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // sample_value
  input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0]    s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // alarm_status, alarm_severity, severity_changed, status_changed,
  // value_event, archive_event
  output logic [alm_pkg::RES_TDATA_W-1:0]             m_axis_tdata
);
  import alm_pkg::*;

  localparam int unsigned EW = ((VALUE_WIDTH > CFG_DATA_W) ? VALUE_WIDTH : CFG_DATA_W) + 2;

  logic [CFG_DATA_W-1:0] lim_hh_q, lim_ll_q, lim_h_q, lim_l_q;
  logic [HYST_W-1:0]     hyst_q;
  logic [CFG_DATA_W-1:0] mon_db_q, arch_db_q;
  logic [SEVS_W-1:0]     sevs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_hh_q  <= '0;
      lim_ll_q  <= '0;
      lim_h_q   <= '0;
      lim_l_q   <= '0;
      hyst_q    <= '0;
      mon_db_q  <= '0;
      arch_db_q <= '0;
      sevs_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LIMIT_HIHI: lim_hh_q  <= cfg_data_i;
        REG_LIMIT_LOLO: lim_ll_q  <= cfg_data_i;
        REG_LIMIT_HIGH: lim_h_q   <= cfg_data_i;
        REG_LIMIT_LOW:  lim_l_q   <= cfg_data_i;
        REG_HYST:       hyst_q    <= cfg_data_i[HYST_W-1:0];
        REG_MON_DB:     mon_db_q  <= cfg_data_i;
        REG_ARCH_DB:    arch_db_q <= cfg_data_i;
        REG_SEVS:       sevs_q    <= cfg_data_i[SEVS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic                          in_valid_q;
  logic signed [VALUE_WIDTH-1:0] in_sample_q;
  logic                          out_valid_q;
  result_t                       out_res_q, res_d;
  logic                          advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  // Last status, severity and sample
  logic [STATUS_W-1:0]           last_status_q;
  logic [SEV_W-1:0]              last_sev_q;
  logic signed [VALUE_WIDTH-1:0] last_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_status_q <= ST_NONE;
      last_sev_q    <= SEV_NONE;
      last_sample_q <= '0;
    end else if (advance) begin
      last_status_q <= res_d.alarm_status;
      last_sev_q    <= res_d.alarm_severity;
      last_sample_q <= in_sample_q;
    end
  end

  // Alarm evaluation
  logic signed [VALUE_WIDTH-1:0] lhh_v, lll_v, lh_v, ll_v;
  logic signed [EW-1:0]          val, old, hyst, lhh, lll, lh, ll, delta;
  logic [EW-1:0]                 mag;
  logic [SEV_W-1:0]              sev_hh, sev_ll, sev_h, sev_l;
  logic                          hit_hh, hit_ll, hit_h, hit_l;

  assign lhh_v = VALUE_WIDTH'(lim_hh_q);
  assign lll_v = VALUE_WIDTH'(lim_ll_q);
  assign lh_v  = VALUE_WIDTH'(lim_h_q);
  assign ll_v  = VALUE_WIDTH'(lim_l_q);

  assign val  = EW'(in_sample_q);
  assign old  = EW'(last_sample_q);
  assign lhh  = EW'(lhh_v);
  assign lll  = EW'(lll_v);
  assign lh   = EW'(lh_v);
  assign ll   = EW'(ll_v);
  assign hyst = signed'(EW'(hyst_q));

  assign sev_hh = sevs_q[1:0];
  assign sev_ll = sevs_q[3:2];
  assign sev_h  = sevs_q[5:4];
  assign sev_l  = sevs_q[7:6];

  assign hit_hh = (sev_hh != SEV_NONE) &&
                  ((val >= lhh) || ((last_status_q == ST_HIHI) && (val >= lhh - hyst)));
  assign hit_ll = (sev_ll != SEV_NONE) &&
                  ((val <= lll) || ((last_status_q == ST_LOLO) && (val <= lll + hyst)));
  assign hit_h  = (sev_h != SEV_NONE) &&
                  ((val >= lh) || ((last_status_q == ST_HIGH) && (val >= lh - hyst)));
  assign hit_l  = (sev_l != SEV_NONE) &&
                  ((val <= ll) || ((last_status_q == ST_LOW) && (val <= ll + hyst)));

  assign delta = val - old;
  assign mag   = delta[EW-1] ? EW'(-delta) : EW'(delta);

  always_comb begin
    res_d = '0;
    if (hit_hh) begin
      res_d.alarm_status   = ST_HIHI;
      res_d.alarm_severity = sev_hh;
    end else if (hit_ll) begin
      res_d.alarm_status   = ST_LOLO;
      res_d.alarm_severity = sev_ll;
    end else if (hit_h) begin
      res_d.alarm_status   = ST_HIGH;
      res_d.alarm_severity = sev_h;
    end else if (hit_l) begin
      res_d.alarm_status   = ST_LOW;
      res_d.alarm_severity = sev_l;
    end
    res_d.severity_changed = (res_d.alarm_severity != last_sev_q);
    res_d.status_changed   = (res_d.alarm_status != last_status_q);
    res_d.value_event      = (mag > EW'(mon_db_q));
    res_d.archive_event    = (mag > EW'(arch_db_q));
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = RES_TDATA_W'(out_res_q);

endmodule

@@ hdl/alm_checker.sv @@
// ----------------------------------------------------------------------------
// Alarm monitor checker
// Port-level checks of the result and sample channels of the alarm monitor.
// ----------------------------------------------------------------------------
module alm_port_props (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [alm_pkg::RES_TDATA_W-1:0]  m_axis_tdata
);
  import alm_pkg::*;

  result_t res;
  assign res = m_axis_tdata[RES_W-1:0];

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.alarm_status <= ST_LOW))
    else $error("alarm status out of range");

  a_status_sev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((res.alarm_status == ST_NONE) == (res.alarm_severity == SEV_NONE)))
    else $error("status and severity disagree");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready
    |=> !s_axis_tready || !m_axis_tvalid || m_axis_tready)
    else $error("input accepted past pipeline capacity");

endmodule

bind alarm_limit_and_deadband_monitor alm_port_props u_alm_port_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/alm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm monitor checker
// Watches the config port and both stream channels, keeps its own copy of
// the limits, deadbands and last status, severity and sample, predicts the
// result of every accepted sample and compares results field by field.
// ----------------------------------------------------------------------------
module alm_checker
  import alm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // sample_value
  input  logic [31:0]            s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // alarm_status, alarm_severity, severity_changed, status_changed,
  // value_event, archive_event
  input  logic [RES_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o
);

  logic [31:0]         lim_hihi_q;
  logic [31:0]         lim_lolo_q;
  logic [31:0]         lim_high_q;
  logic [31:0]         lim_low_q;
  logic [HYST_W-1:0]   hyst_q;
  logic [31:0]         mon_db_q;
  logic [31:0]         arch_db_q;
  logic [SEVS_W-1:0]   sevs_q;
  logic [STATUS_W-1:0] last_status_q;
  logic [SEV_W-1:0]    last_sev_q;
  logic [31:0]         last_sample_q;
  result_t             expected_alarms_q[$];

  function automatic bit limit_tripped(bit upper, longint val, logic [31:0] lim_raw,
                                       logic [STATUS_W-1:0] code, logic [SEV_W-1:0] sev);
    longint lim;
    longint band;
    lim  = longint'(signed'(lim_raw));
    band = longint'(hyst_q);
    if (sev == SEV_NONE) return 1'b0;
    if (upper) return (val >= lim) || (last_status_q == code && val >= lim - band);
    return (val <= lim) || (last_status_q == code && val <= lim + band);
  endfunction

  function automatic result_t classify_sample(logic [31:0] raw);
    result_t          res;
    longint           val;
    longint           old;
    longint           delta;
    longint           mag;
    logic [SEV_W-1:0] sev_hh;
    logic [SEV_W-1:0] sev_ll;
    logic [SEV_W-1:0] sev_h;
    logic [SEV_W-1:0] sev_l;
    val    = longint'(signed'(raw));
    old    = longint'(signed'(last_sample_q));
    sev_hh = sevs_q[1:0];
    sev_ll = sevs_q[3:2];
    sev_h  = sevs_q[5:4];
    sev_l  = sevs_q[7:6];
    res    = '0;
    if (limit_tripped(1'b1, val, lim_hihi_q, ST_HIHI, sev_hh)) begin
      res.alarm_status   = ST_HIHI;
      res.alarm_severity = sev_hh;
    end else if (limit_tripped(1'b0, val, lim_lolo_q, ST_LOLO, sev_ll)) begin
      res.alarm_status   = ST_LOLO;
      res.alarm_severity = sev_ll;
    end else if (limit_tripped(1'b1, val, lim_high_q, ST_HIGH, sev_h)) begin
      res.alarm_status   = ST_HIGH;
      res.alarm_severity = sev_h;
    end else if (limit_tripped(1'b0, val, lim_low_q, ST_LOW, sev_l)) begin
      res.alarm_status   = ST_LOW;
      res.alarm_severity = sev_l;
    end
    delta = val - old;
    mag   = (delta < 0) ? -delta : delta;
    res.severity_changed = (res.alarm_severity != last_sev_q);
    res.status_changed   = (res.alarm_status != last_status_q);
    res.value_event      = (mag > longint'(mon_db_q));
    res.archive_event    = (mag > longint'(arch_db_q));
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      lim_hihi_q    = '0;
      lim_lolo_q    = '0;
      lim_high_q    = '0;
      lim_low_q     = '0;
      hyst_q        = '0;
      mon_db_q      = '0;
      arch_db_q     = '0;
      sevs_q        = '0;
      last_status_q = ST_NONE;
      last_sev_q    = SEV_NONE;
      last_sample_q = '0;
      expected_alarms_q.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LIMIT_HIHI: lim_hihi_q = cfg_data_i;
          REG_LIMIT_LOLO: lim_lolo_q = cfg_data_i;
          REG_LIMIT_HIGH: lim_high_q = cfg_data_i;
          REG_LIMIT_LOW:  lim_low_q  = cfg_data_i;
          REG_HYST:       hyst_q     = cfg_data_i[HYST_W-1:0];
          REG_MON_DB:     mon_db_q   = cfg_data_i;
          REG_ARCH_DB:    arch_db_q  = cfg_data_i;
          REG_SEVS:       sevs_q     = cfg_data_i[SEVS_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_W-1:0]);
        if (expected_alarms_q.size() == 0) begin
          $error("result %h arrived with no sample outstanding", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_alarms_q.pop_front();
          check_field("alarm_status", want.alarm_status, got.alarm_status);
          check_field("alarm_severity", want.alarm_severity, got.alarm_severity);
          check_field("severity_changed", want.severity_changed, got.severity_changed);
          check_field("status_changed", want.status_changed, got.status_changed);
          check_field("value_event", want.value_event, got.value_event);
          check_field("archive_event", want.archive_event, got.archive_event);
          checked_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = classify_sample(s_axis_tdata);
        expected_alarms_q.push_back(want);
        last_status_q = want.alarm_status;
        last_sev_q    = want.alarm_severity;
        last_sample_q = s_axis_tdata;
      end
      pending_o = expected_alarms_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm monitor testbench
// Drives directed and random samples through the alarm monitor under several
// limit settings and random back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import alm_pkg::*;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  // sample_value
  logic [31:0]            s_axis_tdata   = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  // alarm_status, alarm_severity, severity_changed, status_changed,
  // value_event, archive_event
  logic [RES_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int alarms_pending;
  int alarms_checked;

  int          tx_idle_pct = 26;
  int          rx_idle_pct = 55;
  logic        rx_hold     = 1'b0;
  event        hold_rx_ev;
  int          n_samples   = 0;
  int          n_settings  = 0;
  logic [31:0] lim_cur[4];
  logic [30:0] hyst_cur;
  longint      walk_center;
  longint      walk_span;
  longint      walk_pos;

  alarm_limit_and_deadband_monitor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  alm_checker checker_i (
    .*,
    .fail_count_o (fail_count),
    .pending_o    (alarms_pending),
    .checked_o    (alarms_checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready = !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always begin
    @(hold_rx_ev);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (80) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
  endtask

  task automatic write_setting(logic [31:0] hh, logic [31:0] ll, logic [31:0] hi,
                               logic [31:0] lo, logic [30:0] hy, logic [31:0] mon,
                               logic [31:0] arch, logic [7:0] sevs);
    write_reg(REG_LIMIT_HIHI, hh);
    write_reg(REG_LIMIT_LOLO, ll);
    write_reg(REG_LIMIT_HIGH, hi);
    write_reg(REG_LIMIT_LOW, lo);
    write_reg(REG_HYST, {1'b0, hy});
    write_reg(REG_MON_DB, mon);
    write_reg(REG_ARCH_DB, arch);
    write_reg(REG_SEVS, {24'b0, sevs});
    cfg_we_i = 1'b0;
    lim_cur  = '{hh, ll, hi, lo};
    hyst_cur = hy;
    n_settings++;
  endtask

  task automatic send_sample(logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_samples++;
  endtask

  // drop valid and hold until every result has come back
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (alarms_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_deadband(longint span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom_range(0, 2 * span);
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned r;
    longint      lim_v;
    longint      off;
    longint      hy;
    r  = $urandom_range(99);
    hy = longint'(hyst_cur);
    if (r < 10) return $urandom;
    if (r < 25) begin
      lim_v = longint'(signed'(lim_cur[$urandom_range(3)]));
      case ($urandom_range(6))
        0: off = 0;
        1: off = -1;
        2: off = 1;
        3: off = -hy;
        4: off = hy;
        5: off = -hy - 1;
        default: off = hy + 1;
      endcase
      walk_pos = lim_v + off;
      return walk_pos[31:0];
    end
    if (walk_pos > walk_center + 4 * walk_span || walk_pos < walk_center - 4 * walk_span)
      walk_pos = walk_center;
    walk_pos = walk_pos + longint'($urandom_range(0, 2 * walk_span)) - walk_span;
    return walk_pos[31:0];
  endfunction

  task automatic random_setting();
    longint lims[4];
    longint jitter;
    walk_center = longint'(signed'($urandom)) >>> 1;
    walk_span   = $urandom_range(16, 1 << 20);
    walk_pos    = walk_center;
    jitter      = walk_span / 2;
    lims[0] = walk_center + 3 * walk_span + $urandom_range(0, jitter);
    lims[1] = walk_center - 3 * walk_span - $urandom_range(0, jitter);
    lims[2] = walk_center + walk_span + $urandom_range(0, jitter);
    lims[3] = walk_center - walk_span - $urandom_range(0, jitter);
    foreach (lims[i]) begin
      if ($urandom_range(7) == 0) lims[i] = longint'(signed'($urandom));
    end
    write_setting(lims[0][31:0], lims[1][31:0], lims[2][31:0], lims[3][31:0],
                  ($urandom_range(3) == 0) ? 31'd0 : 31'($urandom_range(0, walk_span)),
                  pick_deadband(walk_span), pick_deadband(walk_span),
                  8'($urandom_range(255)));
  endtask

  task automatic run_samples(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) -> hold_rx_ev;
      if (i == pause_at) drain_results();
      send_sample(pick_sample());
    end
    drain_results();
  endtask

  initial begin
    logic [31:0] ladder[$];
    logic [31:0] extremes[$];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // hysteresis hold and release, every status, deadband equality
    write_setting(32'sd1000, -32'sd1000, 32'sd500, -32'sd500, 31'd100,
                  32'd50, 32'd200, 8'h5B);
    ladder = '{32'sd0, 32'sd500, 32'sd450, 32'sd399, 32'sd1000, 32'sd900,
               32'sd899, -32'sd500, -32'sd1000, -32'sd900, -32'sd899, -32'sd550,
               32'sd0, 32'sd50, 32'sd101, 32'sd600};
    foreach (ladder[i]) send_sample(ladder[i]);
    drain_results();

    // disabled limit must not hold its alarm
    write_reg(REG_SEVS, 32'h4B);
    cfg_we_i = 1'b0;
    send_sample(32'sd450);
    drain_results();

    // full-range limits, band past the value range, full-scale change
    write_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'hFF);
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    foreach (extremes[i]) send_sample(extremes[i]);
    drain_results();

    walk_center = 0;
    walk_span   = 1 << 30;
    walk_pos    = 0;
    write_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  31'h7FFF_FFFF, 32'd0, 32'd0, 8'hFF);
    run_samples(170, -1, -1);
    random_setting();
    run_samples(170, 20, -1);
    random_setting();
    run_samples(170, -1, -1);

    tx_idle_pct = 55;
    rx_idle_pct = 26;
    random_setting();
    run_samples(170, -1, -1);
    walk_center = 0;
    walk_span   = 1 << 30;
    walk_pos    = 0;
    write_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  31'd0, 32'hFFFF_FFFF, 32'd0, 8'hF0);
    run_samples(170, -1, 85);
    random_setting();
    run_samples(170, -1, -1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int seg = 0; seg < 3; seg++) begin
      random_setting();
      run_samples(170, (seg == 0) ? 10 : -1, -1);
    end

    repeat (8) @(negedge clk_i);
    $display("Covered %0d samples under %0d limit settings, %0d results compared,",
             n_samples, n_settings, alarms_checked);
    $display("with receiver hold-off, sender drain and three idling mixes.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
